### rtl/brta_pkg.sv
// shared types and codes of the boot region table allocator
package brta_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_AVAIL = 2'd0,
    CMD_ADD_RSRV  = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_ALLOC     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NOFIT = 2'd2,
    STAT_ZERO  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_FETCH,
    S_ADD_LOOK,
    S_QRY_FETCH,
    S_QRY_LOOK,
    S_AL_AFETCH,
    S_AL_ALOOK,
    S_AL_GFETCH,
    S_AL_GLOOK,
    S_AL_ALIGN,
    S_AL_CHECK
  } state_t;

endpackage

### rtl/brta_ram.sv
// generic single write port ram with registered read
module brta_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/boot_region_table_allocator_core.sv
// boot region table allocator: sorted available and reserved tables with first-fit allocate
//
// one command item is accepted when start is high and busy is low; busy stays
// high until the item is finished. the result shows on status, is_reserved
// and alloc_addr with done high for exactly one cycle; the receiver cannot
// stall, so nothing waits on the output side.
// each table lives in its own ram (base and size per entry, registered read).
// an add streams the table once through the ram. a query walks the reserved
// table. an allocate walks the available entries in order against the reserved
// gaps until the first fit, then does an add into the reserved table.
// an add to a full table or a zero-length allocate answers without leaving idle.
// reset clears both entry counts and the control state; ram contents are
// never cleared, entries beyond the counts are simply never read.
module boot_region_table_allocator_core
  import brta_pkg::*;
#(
  parameter int MAX_REGIONS = 32,
  parameter int ADDR_BITS   = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [ADDR_BITS-1:0] base_addr,
  input  logic [ADDR_BITS-1:0] length,
  input  logic [31:0]          alignment,
  output logic                 done,
  output logic [1:0]           status,
  output logic                 is_reserved,
  output logic [ADDR_BITS-1:0] alloc_addr
);

  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int UW = (AW > 32 ? AW : 32) + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_REGIONS);

  function automatic logic [AW-1:0] region_end(input logic [AW-1:0] b, input logic [AW-1:0] s);
    logic [AW:0] sum;
    sum = {1'b0, b} + {1'b0, s};
    return sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
  endfunction

  state_t state, state_next;
  cmd_t   cmd;
  logic [AW-1:0] b, len;
  logic [31:0]   almask;
  logic          tsel, inserted, have_cur, last_gap, fit_ok;
  logic [CW-1:0] rp, wp, n, avail_count, rsrv_count, ai, gi;
  logic [AW-1:0] cur_base, cur_size, as_r, ae_r, prev_end, s_r, e_r, up_r;

  logic          av_re, rs_re, av_we, rs_we;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [2*AW-1:0] wr_data, av_rdata, rs_rdata, tab_rdata;
  logic [AW-1:0] d_base, d_size, rs_base, rs_size, av_base, av_size;

  logic          p_en, take_new, ovl, final_wr, p_wr;
  logic [AW-1:0] e_base, e_size, m_base, m_size, c_end, x_end, lo, hi;
  logic [UW-1:0] up_ext, mask_u;
  logic [31:0]   lowbit;
  logic [AW-1:0] gs_lo, ge_hi;

  brta_ram #(.WIDTH(2*AW), .DEPTH(MAX_REGIONS)) u_avail (
    .clk(clk), .we(av_we), .waddr(wr_addr), .wdata(wr_data),
    .re(av_re), .raddr(rd_addr), .rdata(av_rdata)
  );

  brta_ram #(.WIDTH(2*AW), .DEPTH(MAX_REGIONS)) u_rsrv (
    .clk(clk), .we(rs_we), .waddr(wr_addr), .wdata(wr_data),
    .re(rs_re), .raddr(rd_addr), .rdata(rs_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign tab_rdata = tsel ? rs_rdata : av_rdata;
  assign d_base    = tab_rdata[AW-1:0];
  assign d_size    = tab_rdata[2*AW-1:AW];
  assign rs_base   = rs_rdata[AW-1:0];
  assign rs_size   = rs_rdata[2*AW-1:AW];
  assign av_base   = av_rdata[AW-1:0];
  assign av_size   = av_rdata[2*AW-1:AW];
  assign lowbit    = alignment & (~alignment + 32'd1);

  // merge stream: next element and overlap with the held entry
  always_comb begin
    take_new = !inserted && !(b > d_base);
    p_en     = 1'b0;
    final_wr = 1'b0;
    e_base   = d_base;
    e_size   = d_size;
    if (state == S_ADD_FETCH && rp == n) begin
      if (!inserted) begin
        p_en   = 1'b1;
        e_base = b;
        e_size = len;
      end else begin
        final_wr = 1'b1;
      end
    end else if (state == S_ADD_LOOK) begin
      p_en = 1'b1;
      if (take_new) begin
        e_base = b;
        e_size = len;
      end
    end
    c_end  = region_end(cur_base, cur_size);
    x_end  = region_end(e_base, e_size);
    lo     = (cur_base > e_base) ? cur_base : e_base;
    hi     = (c_end < x_end) ? c_end : x_end;
    ovl    = lo < hi;
    m_base = (cur_base < e_base) ? cur_base : e_base;
    m_size = ((c_end > x_end) ? c_end : x_end) - m_base;
    p_wr   = (p_en && have_cur && !ovl) || final_wr;
  end

  // gap intersection and aligned start
  always_comb begin
    gs_lo  = (as_r > prev_end) ? as_r : prev_end;
    ge_hi  = (ae_r < rs_base) ? ae_r : rs_base;
    mask_u = UW'(almask);
    up_ext = UW'(s_r) + mask_u;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(command))
            CMD_ADD_AVAIL: state_next = (avail_count == MAXC) ? S_IDLE : S_ADD_FETCH;
            CMD_ADD_RSRV:  state_next = (rsrv_count == MAXC) ? S_IDLE : S_ADD_FETCH;
            CMD_QUERY:     state_next = S_QRY_FETCH;
            default:       state_next = (length == '0) ? S_IDLE : S_AL_AFETCH;
          endcase
        end
      end
      S_ADD_FETCH: begin
        if (rp != n) state_next = S_ADD_LOOK;
        else if (inserted) state_next = S_IDLE;
      end
      S_ADD_LOOK:  if (!take_new) state_next = S_ADD_FETCH;
      S_QRY_FETCH: state_next = (rp != rsrv_count) ? S_QRY_LOOK : S_IDLE;
      S_QRY_LOOK: begin
        if (b < rs_base || b < region_end(rs_base, rs_size)) state_next = S_IDLE;
        else state_next = S_QRY_FETCH;
      end
      S_AL_AFETCH: state_next = (ai != avail_count) ? S_AL_ALOOK : S_IDLE;
      S_AL_ALOOK:  state_next = S_AL_GFETCH;
      S_AL_GFETCH: state_next = (gi != rsrv_count) ? S_AL_GLOOK : S_AL_ALIGN;
      S_AL_GLOOK:  state_next = S_AL_ALIGN;
      S_AL_ALIGN:  state_next = S_AL_CHECK;
      S_AL_CHECK: begin
        if (fit_ok && up_r <= e_r && (e_r - up_r) >= len) begin
          state_next = (rsrv_count == MAXC) ? S_IDLE : S_ADD_FETCH;
        end else if (last_gap) begin
          state_next = S_AL_AFETCH;
        end else begin
          state_next = S_AL_GFETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    av_re   = 1'b0;
    rs_re   = 1'b0;
    rd_addr = rp[IW-1:0];
    av_we   = p_wr && !tsel;
    rs_we   = p_wr && tsel;
    wr_addr = wp[IW-1:0];
    wr_data = {cur_size, cur_base};
    case (state)
      S_ADD_FETCH: begin
        av_re = (rp != n) && !tsel;
        rs_re = (rp != n) && tsel;
      end
      S_QRY_FETCH: rs_re = (rp != rsrv_count);
      S_AL_AFETCH: begin
        av_re   = (ai != avail_count);
        rd_addr = ai[IW-1:0];
      end
      S_AL_GFETCH: begin
        rs_re   = (gi != rsrv_count);
        rd_addr = gi[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      avail_count <= '0;
      rsrv_count  <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (p_en) begin
        if (!have_cur || !ovl) begin
          cur_base <= e_base;
          cur_size <= e_size;
        end else begin
          cur_base <= m_base;
          cur_size <= m_size;
        end
        have_cur <= 1'b1;
        if (have_cur && !ovl) wp <= wp + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd         <= cmd_t'(command);
            b           <= base_addr;
            len         <= length;
            almask      <= (lowbit == '0) ? 32'd0 : lowbit - 32'd1;
            rp          <= '0;
            wp          <= '0;
            ai          <= '0;
            inserted    <= 1'b0;
            have_cur    <= 1'b0;
            status      <= STAT_OK;
            is_reserved <= 1'b0;
            alloc_addr  <= '0;
            case (cmd_t'(command))
              CMD_ADD_AVAIL: begin
                tsel <= 1'b0;
                n    <= avail_count;
                if (avail_count == MAXC) begin
                  done   <= 1'b1;
                  status <= STAT_FULL;
                end
              end
              CMD_ADD_RSRV: begin
                tsel <= 1'b1;
                n    <= rsrv_count;
                if (rsrv_count == MAXC) begin
                  done   <= 1'b1;
                  status <= STAT_FULL;
                end
              end
              CMD_QUERY: tsel <= 1'b1;
              default: begin
                tsel <= 1'b1;
                if (length == '0) begin
                  done   <= 1'b1;
                  status <= STAT_ZERO;
                end
              end
            endcase
          end
        end
        S_ADD_FETCH: begin
          if (rp == n) begin
            if (!inserted) begin
              inserted <= 1'b1;
            end else begin
              done <= 1'b1;
              if (tsel) rsrv_count <= wp + 1'b1;
              else avail_count <= wp + 1'b1;
              if (cmd == CMD_ALLOC) alloc_addr <= b;
            end
          end
        end
        S_ADD_LOOK: begin
          if (take_new) inserted <= 1'b1;
          else rp <= rp + 1'b1;
        end
        S_QRY_FETCH: if (rp == rsrv_count) done <= 1'b1;
        S_QRY_LOOK: begin
          if (b < rs_base) begin
            done <= 1'b1;
          end else if (b < region_end(rs_base, rs_size)) begin
            done        <= 1'b1;
            is_reserved <= 1'b1;
          end else begin
            rp <= rp + 1'b1;
          end
        end
        S_AL_AFETCH: begin
          if (ai == avail_count) begin
            done   <= 1'b1;
            status <= STAT_NOFIT;
          end
        end
        S_AL_ALOOK: begin
          as_r     <= av_base;
          ae_r     <= region_end(av_base, av_size);
          gi       <= '0;
          prev_end <= '0;
        end
        S_AL_GFETCH: begin
          last_gap <= (gi == rsrv_count);
          if (gi == rsrv_count) begin
            s_r <= gs_lo;
            e_r <= ae_r;
          end
        end
        S_AL_GLOOK: begin
          s_r      <= gs_lo;
          e_r      <= ge_hi;
          prev_end <= region_end(rs_base, rs_size);
        end
        S_AL_ALIGN: begin
          fit_ok <= (s_r < e_r) && ((up_ext >> AW) == '0);
          up_r   <= AW'(up_ext & ~mask_u);
        end
        S_AL_CHECK: begin
          if (fit_ok && up_r <= e_r && (e_r - up_r) >= len) begin
            b        <= up_r;
            n        <= rsrv_count;
            rp       <= '0;
            wp       <= '0;
            inserted <= 1'b0;
            have_cur <= 1'b0;
            if (rsrv_count == MAXC) begin
              done   <= 1'b1;
              status <= STAT_FULL;
            end
          end else if (last_gap) begin
            ai <= ai + 1'b1;
          end else begin
            gi <= gi + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_counts: assert property (@(posedge clk) disable iff (rst)
    avail_count <= MAXC && rsrv_count <= MAXC)
    else $error("table count beyond depth");
  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    (p_wr && state == S_ADD_LOOK) |-> wp < rp + 1'b1)
    else $error("merge write overtakes read pointer");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> alloc_addr == '0)
    else $error("address on failed item");

endmodule
